### hdl/dsa_pkg.sv
// ----------------------------------------------------------------------------
// Double-ended stack allocator package
// Request and register codes, field widths, reset values and the frame type.
// ----------------------------------------------------------------------------
package dsa_pkg;

  localparam int unsigned ADDR_W = 32;
  localparam int unsigned SIZE_IN_W = 24;
  // A rounded request size needs one bit more than the requested size.
  localparam int unsigned SIZE_W = SIZE_IN_W + 1;
  localparam int unsigned REQ_W = 3;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [ADDR_W-1:0] LOW_BASE_RST = 32'h0080_4000;
  localparam logic [ADDR_W-1:0] HIGH_TOP_RST = 32'h0100_0000;
  localparam logic [ADDR_W-1:0] FREE_RST = HIGH_TOP_RST - LOW_BASE_RST;

  localparam logic [SIZE_W-1:0] ALIGN_MASK = SIZE_W'(31);

  typedef enum logic [REQ_W-1:0] {
    REQ_INIT    = 3'd0,
    REQ_PUSH_LO = 3'd1,
    REQ_POP_LO  = 3'd2,
    REQ_PUSH_HI = 3'd3,
    REQ_POP_HI  = 3'd4
  } req_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LOW_BASE = 1'b0,
    CFG_HIGH_TOP = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [SIZE_W-1:0] size;
  } frame_t;

endpackage

### hdl/dsa_if.sv
// ----------------------------------------------------------------------------
// Double-ended stack allocator channels
// Request, response and register write channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface dsa_req_if
  import dsa_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic [REQ_W-1:0]     req_type;
  logic [SIZE_IN_W-1:0] alloc_size;

  modport source (output valid, output req_type, output alloc_size, input ready);
  modport sink   (input valid, input req_type, input alloc_size, output ready);
endinterface

interface dsa_rsp_if
  import dsa_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] block_addr;
  logic [ADDR_W-1:0] free_bytes;
  logic              full_error;

  modport source (output valid, output block_addr, output free_bytes, output full_error,
                  input ready);
  modport sink   (input valid, input block_addr, input free_bytes, input full_error,
                  output ready);
endinterface

interface dsa_cfg_if
  import dsa_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [ADDR_W-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

### hdl/double_ended_stack_allocator.sv
// ----------------------------------------------------------------------------
// Double-ended stack allocator
// Two stacks of frames in one address region, low growing up, high growing down.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive on req_i (init, push low, pop low, push high, pop high)
//   and each accepted request gives exactly one response on rsp_o with the
//   new frame address, the free space between the stacks and a full flag.
//   Register writes on cfg_i set the base of the low stack and the top of the
//   high stack; they take effect at the next init request.
// Latency and throughput:
//   A response is valid in the cycle after its request transfer; one request
//   is taken in every cycle unless a response stalls. The top frame of each
//   stack is held in flops; the frame below is prefetched every cycle from
//   its memory (one read port, registered data), so a pop's new top is ready.
// Reset:
//   Both stacks are empty, the registers hold their default values and the
//   free space is the distance between them. No clearing pass is needed.
// Stalls:
//   The response register is the only buffer. While it holds a response that
//   the receiver has not taken, req_i.ready is low; it is high again in the
//   cycle the pending response transfers.
// ----------------------------------------------------------------------------
module double_ended_stack_allocator
  import dsa_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  dsa_req_if.sink   req_i,
  dsa_rsp_if.source rsp_o,
  dsa_cfg_if.sink   cfg_i
);

  localparam int unsigned DEPTH_W = $clog2(STACK_DEPTH);
  localparam logic [DEPTH_W-1:0] FULL_DEPTH = DEPTH_W'(STACK_DEPTH - 1);
  localparam logic [DEPTH_W-1:0] ONE = DEPTH_W'(1);

  // Configuration registers and the anchor frames they load at init.
  logic [ADDR_W-1:0] low_base_q, high_top_q;
  logic [ADDR_W-1:0] lo_anchor_q, lo_anchor_d, hi_anchor_q, hi_anchor_d;

  // Top frame and depth of each stack, and the running free space.
  frame_t            lo_top_q, lo_top_d, hi_top_q, hi_top_d;
  logic [DEPTH_W-1:0] lo_depth_q, lo_depth_d, hi_depth_q, hi_depth_d;
  logic [ADDR_W-1:0] free_q, free_d;

  // Frame memories. Entry i holds frame i of the stack; entry 0 is never used
  // because the anchor frame lives in flops.
  frame_t lo_mem [STACK_DEPTH];
  frame_t hi_mem [STACK_DEPTH];
  frame_t lo_below_q, hi_below_q;
  logic   lo_wr, hi_wr;

  // Response register.
  logic              rsp_valid_q;
  logic [ADDR_W-1:0] addr_q, addr_d;
  logic              err_q, err_d;

  logic              req_fire;
  logic [SIZE_W-1:0] size_rnd;
  logic [ADDR_W-1:0] lo_end, hi_new;

  assign req_i.ready = !rsp_valid_q || rsp_o.ready;
  assign req_fire    = req_i.valid && req_i.ready;
  assign cfg_i.ready = 1'b1;

  // Round the requested byte count up to a multiple of 32.
  assign size_rnd = ({1'b0, req_i.alloc_size} + ALIGN_MASK) & ~ALIGN_MASK;
  assign lo_end   = lo_top_q.addr + ADDR_W'(lo_top_q.size);
  assign hi_new   = hi_top_q.addr - ADDR_W'(size_rnd);

  always_comb begin
    lo_top_d    = lo_top_q;
    hi_top_d    = hi_top_q;
    lo_depth_d  = lo_depth_q;
    hi_depth_d  = hi_depth_q;
    lo_anchor_d = lo_anchor_q;
    hi_anchor_d = hi_anchor_q;
    free_d      = free_q;
    addr_d      = '0;
    err_d       = 1'b0;
    lo_wr       = 1'b0;
    hi_wr       = 1'b0;
    if (req_fire) begin
      case (req_e'(req_i.req_type))
        REQ_INIT: begin
          lo_anchor_d = low_base_q;
          hi_anchor_d = high_top_q;
          lo_top_d    = '{addr: low_base_q, size: '0};
          hi_top_d    = '{addr: high_top_q, size: '0};
          lo_depth_d  = '0;
          hi_depth_d  = '0;
          free_d      = high_top_q - low_base_q;
        end
        REQ_PUSH_LO: begin
          if (lo_depth_q == FULL_DEPTH) begin
            err_d = 1'b1;
          end else begin
            lo_wr      = 1'b1;
            lo_top_d   = '{addr: lo_end, size: size_rnd};
            lo_depth_d = lo_depth_q + ONE;
            free_d     = hi_top_q.addr - (lo_end + ADDR_W'(size_rnd));
            addr_d     = lo_end;
          end
        end
        REQ_POP_LO: begin
          if (lo_depth_q != '0) begin
            free_d     = free_q + ADDR_W'(lo_top_q.size);
            lo_depth_d = lo_depth_q - ONE;
            lo_top_d   = (lo_depth_q == ONE) ? frame_t'{addr: lo_anchor_q, size: '0}
                                             : lo_below_q;
          end
        end
        REQ_PUSH_HI: begin
          if (hi_depth_q == FULL_DEPTH) begin
            err_d = 1'b1;
          end else begin
            hi_wr      = 1'b1;
            hi_top_d   = '{addr: hi_new, size: size_rnd};
            hi_depth_d = hi_depth_q + ONE;
            free_d     = hi_new - lo_end;
            addr_d     = hi_new;
          end
        end
        REQ_POP_HI: begin
          if (hi_depth_q != '0) begin
            free_d     = free_q + ADDR_W'(hi_top_q.size);
            hi_depth_d = hi_depth_q - ONE;
            hi_top_d   = (hi_depth_q == ONE) ? frame_t'{addr: hi_anchor_q, size: '0}
                                             : hi_below_q;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Control state, configuration and response register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_base_q  <= LOW_BASE_RST;
      high_top_q  <= HIGH_TOP_RST;
      lo_anchor_q <= LOW_BASE_RST;
      hi_anchor_q <= HIGH_TOP_RST;
      lo_top_q    <= '{addr: LOW_BASE_RST, size: '0};
      hi_top_q    <= '{addr: HIGH_TOP_RST, size: '0};
      lo_depth_q  <= '0;
      hi_depth_q  <= '0;
      free_q      <= FREE_RST;
      rsp_valid_q <= 1'b0;
    end else begin
      if (cfg_i.valid) begin
        case (cfg_idx_e'(cfg_i.index))
          CFG_LOW_BASE: low_base_q <= cfg_i.data;
          CFG_HIGH_TOP: high_top_q <= cfg_i.data;
          default: begin
          end
        endcase
      end
      lo_anchor_q <= lo_anchor_d;
      hi_anchor_q <= hi_anchor_d;
      lo_top_q    <= lo_top_d;
      hi_top_q    <= hi_top_d;
      lo_depth_q  <= lo_depth_d;
      hi_depth_q  <= hi_depth_d;
      free_q      <= free_d;
      if (req_fire) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      addr_q <= addr_d;
      err_q  <= err_d;
    end
  end

  // Frame memories: a push writes the new top, and every cycle the frame just
  // below the next top is read so that a pop can take it without waiting.
  always_ff @(posedge clk_i) begin
    if (lo_wr) begin
      lo_mem[lo_depth_d] <= lo_top_d;
    end
    lo_below_q <= lo_mem[lo_depth_d - ONE];
  end

  always_ff @(posedge clk_i) begin
    if (hi_wr) begin
      hi_mem[hi_depth_d] <= hi_top_d;
    end
    hi_below_q <= hi_mem[hi_depth_d - ONE];
  end

  assign rsp_o.valid      = rsp_valid_q;
  assign rsp_o.block_addr = addr_q;
  assign rsp_o.free_bytes = free_q;
  assign rsp_o.full_error = err_q;

endmodule

### hdl/dsa_checker.sv
// ----------------------------------------------------------------------------
// Double-ended stack allocator checker
// Port-level assertions on the request and response channels.
// ----------------------------------------------------------------------------
module dsa_checker
  import dsa_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              req_valid_i,
  input logic              req_ready_i,
  input logic              rsp_valid_i,
  input logic              rsp_ready_i,
  input logic [ADDR_W-1:0] block_addr_i,
  input logic              full_error_i
);

  // Every request transfer is answered in the following cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> rsp_valid_i)
    else $error("request transfer not followed by a response");

  // With the response register empty, a request is always taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !rsp_valid_i |-> req_ready_i)
    else $error("request stalled while no response is pending");

  // A rejected push reports no address.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && full_error_i |-> block_addr_i == '0)
    else $error("full error with a nonzero block address");

  // A stalled response stays valid.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i)
    else $error("response dropped before its transfer");

endmodule

bind double_ended_stack_allocator dsa_checker u_dsa_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .req_valid_i  (req_i.valid),
  .req_ready_i  (req_i.ready),
  .rsp_valid_i  (rsp_o.valid),
  .rsp_ready_i  (rsp_o.ready),
  .block_addr_i (rsp_o.block_addr),
  .full_error_i (rsp_o.full_error)
);

### tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Double-ended stack allocator testbench
// Drives init, push and pop requests and register writes into the allocator.
// A scoreboard keeps its own model of both stacks and compares every response
// field by field, while the sender and the receiver idle at random.
// ----------------------------------------------------------------------------
module testbench;
  import dsa_pkg::*;

  localparam int unsigned STACK_DEPTH = 32;
  localparam int unsigned PHASES = 8;
  localparam int unsigned ITEMS_PER_PHASE = 104;
  localparam int unsigned CYCLE_LIMIT = 200000;
  // The response comes in the cycle after its request, so the quiet spell at
  // the end is plenty to catch any stray response.
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned MAX_PRINTED = 30;
  // Request codes above the last defined one are ignored by the block.
  localparam int unsigned FIRST_UNUSED_REQ = int'(REQ_POP_HI) + 1;
  localparam int unsigned LAST_REQ_CODE = (1 << REQ_W) - 1;

  typedef struct packed {
    logic [ADDR_W-1:0] block_addr;
    logic [ADDR_W-1:0] free_bytes;
    logic              full_error;
  } alloc_result_t;

  // Scoreboard: holds its own copy of both stacks and of the two registers,
  // predicts the response of every accepted request and checks the block's
  // responses in order against those predictions.
  class alloc_scoreboard;
    logic [ADDR_W-1:0] lo_addr [STACK_DEPTH];
    logic [ADDR_W-1:0] lo_size [STACK_DEPTH];
    logic [ADDR_W-1:0] hi_addr [STACK_DEPTH];
    logic [ADDR_W-1:0] hi_size [STACK_DEPTH];
    int unsigned lo_depth;
    int unsigned hi_depth;
    logic [ADDR_W-1:0] free_space;
    logic [ADDR_W-1:0] base_reg;
    logic [ADDR_W-1:0] top_reg;
    alloc_result_t expected_q[$];
    int unsigned error_count;
    int unsigned compared;
    int unsigned requests;
    int unsigned pushes;
    int unsigned pops;
    int unsigned full_rejects;
    int unsigned empty_pops;
    int unsigned ignored;

    function new();
      base_reg = LOW_BASE_RST;
      top_reg = HIGH_TOP_RST;
      clear_stacks();
    endfunction

    function void clear_stacks();
      for (int i = 0; i < STACK_DEPTH; i++) begin
        lo_addr[i] = '0;
        lo_size[i] = '0;
        hi_addr[i] = '0;
        hi_size[i] = '0;
      end
      lo_addr[0] = base_reg;
      hi_addr[0] = top_reg;
      lo_depth = 0;
      hi_depth = 0;
      free_space = top_reg - base_reg;
    endfunction

    // Written registers only matter at the next init.
    function void write_register(cfg_idx_e idx, logic [ADDR_W-1:0] value);
      if (idx == CFG_LOW_BASE) begin
        base_reg = value;
      end else begin
        top_reg = value;
      end
    endfunction

    function logic [ADDR_W-1:0] rounded_size(logic [SIZE_IN_W-1:0] size);
      return (ADDR_W'(size) + ADDR_W'(31)) & ~ADDR_W'(31);
    endfunction

    function void note_request(logic [REQ_W-1:0] code, logic [SIZE_IN_W-1:0] size);
      alloc_result_t res;
      logic [ADDR_W-1:0] rsize;
      logic [ADDR_W-1:0] frame;
      res = '0;
      requests++;
      case (code)
        REQ_INIT: begin
          clear_stacks();
        end
        REQ_PUSH_LO: begin
          pushes++;
          if (lo_depth >= STACK_DEPTH - 1) begin
            res.full_error = 1'b1;
            full_rejects++;
          end else begin
            rsize = rounded_size(size);
            frame = lo_addr[lo_depth] + lo_size[lo_depth];
            lo_depth++;
            lo_addr[lo_depth] = frame;
            lo_size[lo_depth] = rsize;
            free_space = hi_addr[hi_depth] - (frame + rsize);
            res.block_addr = frame;
          end
        end
        REQ_PUSH_HI: begin
          pushes++;
          if (hi_depth >= STACK_DEPTH - 1) begin
            res.full_error = 1'b1;
            full_rejects++;
          end else begin
            rsize = rounded_size(size);
            frame = hi_addr[hi_depth] - rsize;
            hi_depth++;
            hi_addr[hi_depth] = frame;
            hi_size[hi_depth] = rsize;
            free_space = frame - (lo_addr[lo_depth] + lo_size[lo_depth]);
            res.block_addr = frame;
          end
        end
        REQ_POP_LO: begin
          pops++;
          if (lo_depth == 0) begin
            empty_pops++;
          end else begin
            free_space += lo_size[lo_depth];
            lo_addr[lo_depth] = '0;
            lo_size[lo_depth] = '0;
            lo_depth--;
          end
        end
        REQ_POP_HI: begin
          pops++;
          if (hi_depth == 0) begin
            empty_pops++;
          end else begin
            free_space += hi_size[hi_depth];
            hi_addr[hi_depth] = '0;
            hi_size[hi_depth] = '0;
            hi_depth--;
          end
        end
        default: begin
          ignored++;
        end
      endcase
      res.free_bytes = free_space;
      expected_q.push_back(res);
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    task report_mismatch(string what);
      error_count++;
      if (error_count <= MAX_PRINTED) begin
        $display("[%0t] mismatch: %s", $time, what);
      end
    endtask

    task check_response(alloc_result_t got);
      alloc_result_t want;
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("response with nothing expected (addr %h free %h err %b)",
                                  got.block_addr, got.free_bytes, got.full_error));
      end else begin
        want = expected_q.pop_front();
        compared++;
        if (got.block_addr !== want.block_addr) begin
          report_mismatch($sformatf("block_addr %h, expected %h",
                                    got.block_addr, want.block_addr));
        end
        if (got.free_bytes !== want.free_bytes) begin
          report_mismatch($sformatf("free_bytes %h, expected %h",
                                    got.free_bytes, want.free_bytes));
        end
        if (got.full_error !== want.full_error) begin
          report_mismatch($sformatf("full_error %b, expected %b",
                                    got.full_error, want.full_error));
        end
      end
    endtask

    task check_leftovers();
      while (expected_q.size() != 0) begin
        void'(expected_q.pop_front());
        report_mismatch("expected response never arrived");
      end
    endtask
  endclass

  logic clk_i;
  logic rst_ni;

  dsa_req_if req_bus ();
  dsa_rsp_if rsp_bus ();
  dsa_cfg_if cfg_bus ();

  alloc_scoreboard sb = new();

  // Idle rates in percent of cycles, changed from phase to phase.
  int unsigned idle_pct;
  int unsigned stall_pct;
  int unsigned cycle_count;
  int unsigned settings_count;

  double_ended_stack_allocator #(
    .STACK_DEPTH(STACK_DEPTH)
  ) u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_bus),
    .rsp_o (rsp_bus),
    .cfg_i (cfg_bus)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // The watchdog: a run that hangs on a handshake fails here.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", CYCLE_LIMIT);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // The receiver stalls at random. The value is redrawn at every edge so the
  // stalls land on every phase of the block's work.
  always @(posedge clk_i) begin
    rsp_bus.ready <= ($urandom_range(99) >= stall_pct);
  end

  // Every response transfer is compared with the oldest prediction. Values are
  // read right after the edge, before any update scheduled at that edge lands.
  always @(posedge clk_i) begin
    if (rst_ni && rsp_bus.valid && rsp_bus.ready) begin
      sb.check_response('{block_addr: rsp_bus.block_addr,
                          free_bytes: rsp_bus.free_bytes,
                          full_error: rsp_bus.full_error});
    end
  end

  // Offers one request, with random idle cycles in front of it, and returns at
  // the edge where it transfers. Valid stays high after the transfer so that
  // back-to-back requests see no bubble; only idling or the drain lowers it.
  task automatic send_request(input logic [REQ_W-1:0] code,
                              input logic [SIZE_IN_W-1:0] size);
    while ($urandom_range(99) < idle_pct) begin
      req_bus.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_bus.valid <= 1'b1;
    req_bus.req_type <= code;
    req_bus.alloc_size <= size;
    do begin
      @(posedge clk_i);
    end while (!req_bus.ready);
    sb.note_request(code, size);
  endtask

  // Holds off the sender until every predicted response has been checked.
  task automatic drain_responses();
    req_bus.valid <= 1'b0;
    while (sb.pending() != 0) begin
      @(posedge clk_i);
    end
  endtask

  // Writes both registers back to back while the request side is quiet.
  task automatic write_registers(input logic [ADDR_W-1:0] base_value,
                                 input logic [ADDR_W-1:0] top_value);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= CFG_LOW_BASE;
    cfg_bus.data <= base_value;
    do begin
      @(posedge clk_i);
    end while (!cfg_bus.ready);
    sb.write_register(CFG_LOW_BASE, base_value);
    cfg_bus.index <= CFG_HIGH_TOP;
    cfg_bus.data <= top_value;
    do begin
      @(posedge clk_i);
    end while (!cfg_bus.ready);
    sb.write_register(CFG_HIGH_TOP, top_value);
    cfg_bus.valid <= 1'b0;
    settings_count++;
  endtask

  // Mostly small sizes keep the stacks from wrapping all the time; full-width
  // values exercise every bit, and the rounding edges come up now and then.
  function automatic logic [SIZE_IN_W-1:0] pick_size();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 60) begin
      return SIZE_IN_W'($urandom_range(0, 256));
    end else if (roll < 85) begin
      return SIZE_IN_W'($urandom);
    end else if (roll < 92) begin
      return SIZE_IN_W'($urandom_range(0, 1) * 32 + $urandom_range(0, 1));
    end else begin
      return {SIZE_IN_W{1'b1}} - SIZE_IN_W'($urandom_range(0, 32));
    end
  endfunction

  // Random traffic in bursts, each with its own mix. Pure fill bursts run a
  // stack into its full state and then keep pushing; the mixed bursts walk the
  // stacks up and down; the uniform mix also brings in inits and the unused
  // request codes.
  task automatic random_traffic(input int unsigned count, input bit with_pause);
    int unsigned mix;
    int unsigned left;
    int unsigned roll;
    logic [REQ_W-1:0] code;
    left = 0;
    mix = 0;
    for (int unsigned i = 0; i < count; i++) begin
      if (left == 0) begin
        mix = $urandom_range(0, 4);
        left = (mix <= 1) ? $urandom_range(32, 40) : $urandom_range(8, 30);
      end
      left--;
      roll = $urandom_range(99);
      case (mix)
        0: code = REQ_PUSH_LO;
        1: code = REQ_PUSH_HI;
        2: begin
          if (roll < 40) code = REQ_PUSH_LO;
          else if (roll < 80) code = REQ_PUSH_HI;
          else if (roll < 88) code = REQ_POP_LO;
          else if (roll < 96) code = REQ_POP_HI;
          else code = REQ_INIT;
        end
        3: begin
          if (roll < 15) code = REQ_PUSH_LO;
          else if (roll < 30) code = REQ_PUSH_HI;
          else if (roll < 62) code = REQ_POP_LO;
          else if (roll < 94) code = REQ_POP_HI;
          else code = REQ_W'($urandom_range(FIRST_UNUSED_REQ, LAST_REQ_CODE));
        end
        default: code = REQ_W'($urandom_range(0, LAST_REQ_CODE));
      endcase
      if (with_pause && i == count / 2) begin
        drain_responses();
      end
      send_request(code, pick_size());
    end
  endtask

  initial begin
    logic [ADDR_W-1:0] base_value;
    logic [ADDR_W-1:0] top_value;
    idle_pct = 0;
    stall_pct = 0;
    cycle_count = 0;
    settings_count = 0;
    rst_ni <= 1'b0;
    req_bus.valid <= 1'b0;
    req_bus.req_type <= REQ_INIT;
    req_bus.alloc_size <= '0;
    cfg_bus.valid <= 1'b0;
    cfg_bus.index <= CFG_LOW_BASE;
    cfg_bus.data <= '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part, on the reset values of the registers: pops of empty
    // stacks, the rounding edges of the size, full-width sizes with
    // alternating bits, pops that give space back, and the unused codes.
    send_request(REQ_POP_LO, '0);
    send_request(REQ_POP_HI, '1);
    send_request(REQ_PUSH_LO, 24'd0);
    send_request(REQ_PUSH_LO, 24'd1);
    send_request(REQ_PUSH_LO, 24'd31);
    send_request(REQ_PUSH_LO, 24'd32);
    send_request(REQ_PUSH_LO, 24'd33);
    send_request(REQ_PUSH_LO, 24'hFF_FFFF);
    send_request(REQ_PUSH_HI, 24'd0);
    send_request(REQ_PUSH_HI, 24'hAA_AAAA);
    send_request(REQ_PUSH_HI, 24'h55_5555);
    send_request(REQ_PUSH_HI, 24'hFF_FFFF);
    send_request(REQ_POP_LO, 24'd7);
    send_request(REQ_POP_HI, 24'd7);
    send_request(REQ_POP_LO, 24'd0);
    for (int unsigned c = FIRST_UNUSED_REQ; c <= LAST_REQ_CODE; c++) begin
      send_request(REQ_W'(c), SIZE_IN_W'($urandom));
    end
    send_request(REQ_INIT, 24'hFF_FFFF);
    send_request(REQ_PUSH_HI, 24'd64);
    send_request(REQ_PUSH_LO, 24'd100);

    // Each phase runs with its own register setting and idle pattern. The
    // registers are only written once the block has nothing in flight; in odd
    // phases a few requests go in before the init to show that the new values
    // stay dormant until then.
    for (int unsigned phase = 0; phase < PHASES; phase++) begin
      case (phase % 4)
        0: begin idle_pct = 0; stall_pct = 0; end
        1: begin idle_pct = 50; stall_pct = 0; end
        2: begin idle_pct = 0; stall_pct = 50; end
        default: begin idle_pct = 10; stall_pct = 10; end
      endcase
      case (phase)
        0: begin base_value = LOW_BASE_RST; top_value = HIGH_TOP_RST; end
        1: begin base_value = '0; top_value = '1; end
        2: begin base_value = '1; top_value = '0; end
        4: begin base_value = '0; top_value = '0; end
        5: begin base_value = '1; top_value = '1; end
        6: begin base_value = $urandom & ~ADDR_W'(31); top_value = $urandom; end
        default: begin base_value = $urandom; top_value = $urandom; end
      endcase
      drain_responses();
      write_registers(base_value, top_value);
      if (phase % 2 == 1) begin
        random_traffic(3, 1'b0);
      end
      send_request(REQ_INIT, pick_size());
      random_traffic(ITEMS_PER_PHASE, phase % 2 == 1);
    end

    drain_responses();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    sb.check_leftovers();

    $display("Covered %0d requests (%0d pushes, %0d pops, %0d unused codes) over %0d settings",
             sb.requests, sb.pushes, sb.pops, sb.ignored, settings_count + 1);
    $display("Compared %0d responses; %0d full-stack rejects, %0d pops of an empty stack",
             sb.compared, sb.full_rejects, sb.empty_pops);
    if (sb.error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
